// ===== design/sst_pkg.sv =====
// Shared types and constants for the stream slot table.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int unsigned SST_SLOTS = 16;
  localparam int unsigned SST_LIMIT_RESET = 16;
  localparam int unsigned SST_CFG_W = 5;
  localparam int unsigned SST_ID_W = 31;
  localparam int unsigned SST_SLOT_W = 4;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CTRL_IDLE = 1'b0,
    CTRL_SCAN = 1'b1
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

// ===== design/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sst_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sst_ctrl.sv =====
// Command sequencer for the stream slot table.
`timescale 1ns / 1ps

module sst_ctrl
  import sst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: begin
        if (start_i) begin
          state_d = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        if (status_i.done) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        cmd_o.load = start_i;
      end
      CTRL_SCAN: begin
        busy_o       = 1'b1;
        cmd_o.scan   = 1'b1;
        cmd_o.finish = status_i.done;
      end
      default: busy_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/sst_datapath.sv =====
// Slot scan, valid marks, identifier store and result registers.
`timescale 1ns / 1ps

module sst_datapath
  import sst_pkg::*;
#(
  parameter int unsigned SLOTS = SST_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [1:0]            cmd_in_i,
  input  logic [SST_ID_W-1:0]   stream_id_i,
  input  logic [SST_CFG_W-1:0]  limit_cfg_i,
  output logic                  done_o,
  output logic [1:0]            status_res_o,
  output logic                  found_o,
  output logic [SST_SLOT_W-1:0] slot_index_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned CW = (LW > SST_CFG_W) ? LW : SST_CFG_W;

  cmd_e                op_q;
  logic [SST_ID_W-1:0] id_q;
  logic [LW-1:0]       lim_q, lim_d;
  logic [LW-1:0]       idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [IW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                empty_q, empty_d;
  logic [IW-1:0]       empty_idx_q, empty_idx_d;
  logic [SLOTS-1:0]    valid_q, valid_d;

  logic [SST_ID_W-1:0] rdata;
  logic                hit;
  logic                scan_end;
  logic                ram_we;
  logic [CW-1:0]       cfg_ext;

  logic                done_q;
  status_e             res_status_q, res_status_d;
  logic                res_found_q, res_found_d;
  logic [IW-1:0]       res_idx_q, res_idx_d;
  logic [IW+SST_SLOT_W-1:0] res_idx_ext;

  // Saturate the configured limit to the table size.
  assign cfg_ext = CW'(limit_cfg_i);
  assign lim_d   = (cfg_ext > CW'(SLOTS)) ? LW'(SLOTS) : LW'(cfg_ext);

  sst_ram #(
    .WIDTH (SST_ID_W),
    .DEPTH (SLOTS)
  ) u_ident_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (empty_idx_q),
    .wdata_i (id_q),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  assign hit      = pend_q && valid_q[cmp_idx_q] && (rdata == id_q) && (op_q != CMD_CLEAR);
  assign scan_end = !pend_q && (idx_q >= lim_q);
  assign status_o.done = (op_q == CMD_CLEAR) || hit || scan_end;

  assign ram_we = cmd_i.finish && (op_q == CMD_CREATE) && !hit && empty_q;

  always_comb begin
    idx_d       = idx_q;
    pend_d      = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    if (cmd_i.load) begin
      idx_d   = '0;
      empty_d = 1'b0;
    end else if (cmd_i.scan) begin
      if (idx_q < lim_q) begin
        pend_d    = 1'b1;
        cmp_idx_d = idx_q[IW-1:0];
        idx_d     = idx_q + LW'(1);
      end
      // Remember the lowest empty slot seen so far.
      if (pend_q && !valid_q[cmp_idx_q] && !empty_q) begin
        empty_d     = 1'b1;
        empty_idx_d = cmp_idx_q;
      end
    end
  end

  always_comb begin
    valid_d      = valid_q;
    res_status_d = ST_OK;
    res_found_d  = 1'b0;
    res_idx_d    = '0;
    unique case (op_q)
      CMD_CREATE: begin
        if (hit) begin
          res_status_d = ST_EXISTS;
          res_found_d  = 1'b1;
          res_idx_d    = cmp_idx_q;
        end else if (empty_q) begin
          res_found_d  = 1'b1;
          res_idx_d    = empty_idx_q;
          valid_d[empty_idx_q] = 1'b1;
        end else begin
          res_status_d = ST_FULL;
        end
      end
      CMD_DESTROY: begin
        if (hit) begin
          res_found_d  = 1'b1;
          res_idx_d    = cmp_idx_q;
          valid_d[cmp_idx_q] = 1'b0;
        end else begin
          res_status_d = ST_NOTFOUND;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_idx_d   = cmp_idx_q;
        end else begin
          res_status_d = ST_NOTFOUND;
        end
      end
      CMD_CLEAR: begin
        valid_d = '0;
      end
      default: valid_d = valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
      empty_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      done_q  <= cmd_i.finish;
      pend_q  <= pend_d;
      empty_q <= empty_d;
      idx_q   <= idx_d;
      if (cmd_i.finish) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    empty_idx_q <= empty_idx_d;
    if (cmd_i.load) begin
      op_q  <= cmd_e'(cmd_in_i);
      id_q  <= stream_id_i;
      lim_q <= lim_d;
    end
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_idx_q    <= res_idx_d;
    end
  end

  assign res_idx_ext  = {{SST_SLOT_W{1'b0}}, res_idx_q};
  assign done_o       = done_q;
  assign status_res_o = res_status_q;
  assign found_o      = res_found_q;
  assign slot_index_o = res_idx_ext[SST_SLOT_W-1:0];

endmodule

// ===== design/stream_slot_table.sv =====
// Top level of the stream slot table: sequencer plus scan datapath.
//
//   channel   direction  handshake                   payload
//   command   in         start && !busy              cmd_i, stream_id_i
//   result    out        done_o, one cycle           status_o, found_o, slot_index_o
//   config    in         cfg_valid_i && cfg_ready_o  cfg_data_i (active slot limit)
//
// A create, destroy or lookup scans the slots below the active limit L, one
// identifier read from the store each cycle, and keeps busy high until the
// scan ends; a hit ends the scan early. Clear and a zero limit end without
// any identifier compare. The result register loads at the edge that ends
// the last busy cycle, and done_o pulses in the cycle right after it, together
// with the result, while the next item may already be accepted. The result
// side cannot stall. Reset empties every slot at once through the valid marks
// and sets the limit to 16; the identifier store itself is not cleared.
`timescale 1ns / 1ps

module stream_slot_table
  import sst_pkg::*;
#(
  parameter int unsigned SLOTS = SST_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd_i,
  input  logic [SST_ID_W-1:0]   stream_id_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic                  found_o,
  output logic [SST_SLOT_W-1:0] slot_index_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [SST_CFG_W-1:0]  cfg_data_i
);

  dp_cmd_t              dp_cmd;
  dp_status_t           dp_status;
  logic [SST_CFG_W-1:0] limit_q;

  // Always take configuration writes; an item in flight keeps the limit it
  // was accepted with, so a new limit applies from the next item on.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SST_CFG_W'(SST_LIMIT_RESET);
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Sequence each item: load on accept, scan until the datapath reports done.
  sst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy_o   (busy)
  );

  // Hold valid marks and identifiers, compare, allocate and drop slots.
  sst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .cmd_in_i     (cmd_i),
    .stream_id_i  (stream_id_i),
    .limit_cfg_i  (limit_q),
    .done_o       (done_o),
    .status_res_o (status_o),
    .found_o      (found_o),
    .slot_index_o (slot_index_o)
  );

endmodule
